### design/rgtg_pkg.sv
// ----------------------------------------------------------------------------
// rgtg_pkg
// Shared types and constants of the ASCII RGB to gray text converter.
// ----------------------------------------------------------------------------
package rgtg_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int DIM_BITS       = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;
	localparam int DIGIT_COUNT    = 5;
	localparam int COUNT_BITS     = 3;
	localparam int WEIGHT_BITS    = 10;
	localparam int SUM_BITS       = SAMPLE_BITS + WEIGHT_BITS;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [7:0] ASCII_ZERO    = 8'd48;
	localparam logic [7:0] ASCII_NINE    = 8'd57;
	localparam logic [7:0] ASCII_SPACE   = 8'd32;
	localparam logic [7:0] ASCII_NEWLINE = 8'd10;

	// bt.601 luma weights, scaled by 1000
	localparam logic [WEIGHT_BITS-1:0] W_RED   = 10'd299;
	localparam logic [WEIGHT_BITS-1:0] W_GREEN = 10'd587;
	localparam logic [WEIGHT_BITS-1:0] W_BLUE  = 10'd114;

	// sum / 1000 as multiply by ceil(2^36 / 1000), exact for sums below 2^26
	localparam int               SUM_RECIP_BITS  = 27;
	localparam int               SUM_RECIP_SHIFT = 36;
	localparam logic [SUM_RECIP_BITS-1:0] RECIP_SUM_1000 = 27'd68719477;

	// 16-bit value / 10^k as multiply by a rounded-up reciprocal
	localparam int RECIP_BITS = 17;
	localparam logic [RECIP_BITS-1:0] RECIP_10    = 17'd52429;
	localparam logic [RECIP_BITS-1:0] RECIP_100   = 17'd83887;
	localparam logic [RECIP_BITS-1:0] RECIP_1000  = 17'd67109;
	localparam logic [RECIP_BITS-1:0] RECIP_10000 = 17'd107375;
	localparam int SHIFT_10    = 19;
	localparam int SHIFT_100   = 23;
	localparam int SHIFT_1000  = 26;
	localparam int SHIFT_10000 = 30;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DIM_BITS-1:0]    dim_t;
	typedef logic [3:0]             digit_t;

	typedef enum logic [1:0] {
		COMP_RED,
		COMP_GREEN,
		COMP_BLUE
	} comp_t;

	typedef struct packed {
		dim_t width;
		dim_t height;
	} dims_t;

	typedef struct packed {
		sample_t red;
		sample_t green;
		sample_t blue;
		logic    newline;
	} pixel_t;

	typedef struct packed {
		sample_t value;
		logic    newline;
	} gray_t;

	typedef struct packed {
		digit_t [DIGIT_COUNT-1:0] digits;
		logic [COUNT_BITS-1:0]    count;
		logic                     newline;
	} text_t;

endpackage

### design/rgtg_in_if.sv
// ----------------------------------------------------------------------------
// rgtg_in_if
// Byte channel carrying the RGB pixel text into the converter.
// ----------------------------------------------------------------------------
interface rgtg_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       stream_end;

	modport source (output valid, output byte_value, output stream_end, input ready);
	modport sink   (input valid, input byte_value, input stream_end, output ready);
endinterface

### design/rgtg_out_if.sv
// ----------------------------------------------------------------------------
// rgtg_out_if
// Byte channel carrying the gray text out of the converter.
// ----------------------------------------------------------------------------
interface rgtg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

### design/rgtg_parser.sv
// ----------------------------------------------------------------------------
// rgtg_parser
// Gathers decimal numbers into red, green and blue, tracks rows and columns
// and hands one pixel item per finished blue value to the luma stage.
// ----------------------------------------------------------------------------
module rgtg_parser (
	input  logic             clk,
	input  logic             arst_n,
	rgtg_in_if.sink          rgb_in,
	input  rgtg_pkg::dims_t  dims,
	output logic             pix_valid,
	input  logic             pix_ready,
	output rgtg_pkg::pixel_t pix
);
	import rgtg_pkg::*;

	sample_t acc_q;
	logic    pending_q;
	comp_t   comp_q;
	sample_t red_q;
	sample_t green_q;
	dim_t    col_q;
	dim_t    row_q;
	logic    done_q;

	logic    pix_valid_s1;
	pixel_t  pix_s1;

	logic                   accept;
	logic                   is_digit;
	logic                   delim;
	logic                   finish;
	logic                   emit;
	logic [3:0]             digit_byte;
	logic [SAMPLE_BITS+3:0] acc_wide;
	sample_t                acc_next;
	dim_t                   col_inc;
	dim_t                   row_inc;
	logic                   eol;
	logic                   last_row;

	assign rgb_in.ready = !pix_valid_s1 || pix_ready;
	assign accept       = rgb_in.valid && rgb_in.ready;

	assign is_digit   = (rgb_in.byte_value >= ASCII_ZERO) && (rgb_in.byte_value <= ASCII_NINE);
	assign delim      = rgb_in.stream_end || !is_digit;
	assign finish     = !done_q && delim && pending_q;
	assign emit       = finish && (comp_q != COMP_RED) && (comp_q != COMP_GREEN);
	// low nibble of an ascii digit is its value
	assign digit_byte = rgb_in.byte_value[3:0];

	// acc * 10 + digit, saturating
	assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {{SAMPLE_BITS{1'b0}}, digit_byte};
	assign acc_next = (acc_wide[SAMPLE_BITS+3:SAMPLE_BITS] != 4'b0)
		? {SAMPLE_BITS{1'b1}} : acc_wide[SAMPLE_BITS-1:0];

	assign col_inc  = col_q + dim_t'(1);
	assign row_inc  = row_q + dim_t'(1);
	assign eol      = (col_inc == dims.width);
	assign last_row = (row_inc == dims.height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pending_q <= 1'b0;
			comp_q    <= COMP_RED;
			red_q     <= '0;
			green_q   <= '0;
			col_q     <= '0;
			row_q     <= '0;
			done_q    <= 1'b0;
		end else if (accept && !done_q) begin
			if (!delim) begin
				acc_q     <= acc_next;
				pending_q <= 1'b1;
			end else if (pending_q) begin
				acc_q     <= '0;
				pending_q <= 1'b0;
				case (comp_q)
					COMP_RED: begin
						red_q  <= acc_q;
						comp_q <= COMP_GREEN;
					end
					COMP_GREEN: begin
						green_q <= acc_q;
						comp_q  <= COMP_BLUE;
					end
					default: begin
						comp_q <= COMP_RED;
						col_q  <= eol ? '0 : col_inc;
						if (eol) begin
							row_q <= row_inc;
							if (last_row) begin
								done_q <= 1'b1;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (rgb_in.ready) begin
			pix_valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pix_s1.red     <= red_q;
			pix_s1.green   <= green_q;
			pix_s1.blue    <= acc_q;
			pix_s1.newline <= eol;
		end
	end

	assign pix_valid = pix_valid_s1;
	assign pix       = pix_s1;

	a_idle_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> acc_q == '0)
		else $error("accumulator holds a value with no digit pending");

	a_pixel_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> comp_q == COMP_RED && !pending_q && pix_valid_s1)
		else $error("pixel hand-off did not restart the component sequence");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q && $stable(row_q) && $stable(col_q))
		else $error("counters moved after the image was finished");

endmodule

### design/rgtg_luma.sv
// ----------------------------------------------------------------------------
// rgtg_luma
// Weighted sum of red, green and blue, then division by 1000 through a
// reciprocal multiply, one register stage each.
// ----------------------------------------------------------------------------
module rgtg_luma (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  rgtg_pkg::pixel_t pix,
	output logic             gray_valid,
	input  logic             gray_ready,
	output rgtg_pkg::gray_t  gray
);
	import rgtg_pkg::*;

	localparam int PROD_BITS = SUM_BITS + SUM_RECIP_BITS;

	logic                  valid_s2;
	logic [SUM_BITS-1:0]   sum_s2;
	logic                  newline_s2;
	logic                  valid_s3;
	gray_t                 gray_s3;

	logic                  load_s2;
	logic                  load_s3;
	logic [SUM_BITS-1:0]   sum;
	logic [PROD_BITS-1:0]  quot_prod;

	assign load_s3   = !valid_s3 || gray_ready;
	assign load_s2   = !valid_s2 || load_s3;
	assign pix_ready = load_s2;

	assign sum = SUM_BITS'(pix.red) * SUM_BITS'(W_RED)
		+ SUM_BITS'(pix.green) * SUM_BITS'(W_GREEN)
		+ SUM_BITS'(pix.blue) * SUM_BITS'(W_BLUE);

	assign quot_prod = {{SUM_RECIP_BITS{1'b0}}, sum_s2}
		* {{SUM_BITS{1'b0}}, RECIP_SUM_1000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s2) begin
				valid_s2 <= pix_valid;
			end
			if (load_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && pix_valid) begin
			sum_s2     <= sum;
			newline_s2 <= pix.newline;
		end
		if (load_s3 && valid_s2) begin
			gray_s3.value   <= quot_prod[SUM_RECIP_SHIFT +: SAMPLE_BITS];
			gray_s3.newline <= newline_s2;
		end
	end

	assign gray_valid = valid_s3;
	assign gray       = gray_s3;

endmodule

### design/rgtg_digits.sv
// ----------------------------------------------------------------------------
// rgtg_digits
// Splits the gray value into decimal digits: quotients by 10, 100, 1000 and
// 10000 in one stage, digits and digit count in the next.
// ----------------------------------------------------------------------------
module rgtg_digits (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            gray_valid,
	output logic            gray_ready,
	input  rgtg_pkg::gray_t gray,
	output logic            text_valid,
	input  logic            text_ready,
	output rgtg_pkg::text_t text
);
	import rgtg_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + RECIP_BITS;

	logic                            valid_s4;
	sample_t [DIGIT_COUNT-1:0]       quot_s4;
	logic                            newline_s4;
	logic                            valid_s5;
	text_t                           text_s5;

	logic                            load_s4;
	logic                            load_s5;
	logic [PROD_BITS-1:0]            prod_10;
	logic [PROD_BITS-1:0]            prod_100;
	logic [PROD_BITS-1:0]            prod_1000;
	logic [PROD_BITS-1:0]            prod_10000;
	digit_t [DIGIT_COUNT-1:0]        digits;
	logic [COUNT_BITS-1:0]           count;
	sample_t [DIGIT_COUNT-1:0]       tens;

	assign load_s5    = !valid_s5 || text_ready;
	assign load_s4    = !valid_s4 || load_s5;
	assign gray_ready = load_s4;

	assign prod_10    = {{RECIP_BITS{1'b0}}, gray.value} * {{SAMPLE_BITS{1'b0}}, RECIP_10};
	assign prod_100   = {{RECIP_BITS{1'b0}}, gray.value} * {{SAMPLE_BITS{1'b0}}, RECIP_100};
	assign prod_1000  = {{RECIP_BITS{1'b0}}, gray.value} * {{SAMPLE_BITS{1'b0}}, RECIP_1000};
	assign prod_10000 = {{RECIP_BITS{1'b0}}, gray.value} * {{SAMPLE_BITS{1'b0}}, RECIP_10000};

	// digit k = q[k] - 10 * q[k+1], top digit is the top quotient itself
	always_comb begin
		count = COUNT_BITS'(1);
		tens[DIGIT_COUNT-1] = '0;
		for (int k = 0; k < DIGIT_COUNT - 1; k++) begin
			tens[k] = (quot_s4[k+1] << 3) + (quot_s4[k+1] << 1);
		end
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			digits[k] = digit_t'(quot_s4[k] - tens[k]);
			if (quot_s4[k] != '0) begin
				count = COUNT_BITS'(k + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (load_s4) begin
				valid_s4 <= gray_valid;
			end
			if (load_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4 && gray_valid) begin
			quot_s4[0] <= gray.value;
			quot_s4[1] <= SAMPLE_BITS'(prod_10 >> SHIFT_10);
			quot_s4[2] <= SAMPLE_BITS'(prod_100 >> SHIFT_100);
			quot_s4[3] <= SAMPLE_BITS'(prod_1000 >> SHIFT_1000);
			quot_s4[4] <= SAMPLE_BITS'(prod_10000 >> SHIFT_10000);
			newline_s4 <= gray.newline;
		end
		if (load_s5 && valid_s4) begin
			text_s5.digits  <= digits;
			text_s5.count   <= count;
			text_s5.newline <= newline_s4;
		end
	end

	assign text_valid = valid_s5;
	assign text       = text_s5;

endmodule

### design/rgtg_emitter.sv
// ----------------------------------------------------------------------------
// rgtg_emitter
// Output register: sends the digits of one gray value, most significant
// first, then a space and, at the end of a row, a newline.
// ----------------------------------------------------------------------------
module rgtg_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            text_valid,
	output logic            text_ready,
	input  rgtg_pkg::text_t text,
	rgtg_out_if.source      gray_out
);
	import rgtg_pkg::*;

	logic                  busy_q;
	text_t                 text_q;
	logic [COUNT_BITS-1:0] pos_q;

	logic                  load;
	logic                  last;
	logic [COUNT_BITS-1:0] last_pos;
	logic [COUNT_BITS-1:0] digit_idx;
	logic [COUNT_BITS-1:0] msd_idx;
	digit_t                digit;

	assign last_pos  = text_q.count + COUNT_BITS'(text_q.newline);
	assign last      = (pos_q == last_pos);
	assign msd_idx   = text_q.count - COUNT_BITS'(1);
	assign digit_idx = msd_idx - pos_q;
	assign digit     = text_q.digits[digit_idx];

	assign load       = !busy_q || (gray_out.ready && last);
	assign text_ready = load;

	always_comb begin
		if (pos_q < text_q.count) begin
			gray_out.out_byte = ASCII_ZERO + {4'b0, digit};
		end else if (pos_q == text_q.count) begin
			gray_out.out_byte = ASCII_SPACE;
		end else begin
			gray_out.out_byte = ASCII_NEWLINE;
		end
	end

	assign gray_out.valid       = busy_q;
	assign gray_out.last_of_run = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= text_valid;
			pos_q  <= '0;
		end else if (gray_out.ready) begin
			pos_q <= pos_q + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && text_valid) begin
			text_q <= text;
		end
	end

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q <= last_pos)
		else $error("byte position ran past the end of the item");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> text_q.count >= COUNT_BITS'(1) && text_q.count <= COUNT_BITS'(DIGIT_COUNT))
		else $error("digit count out of range");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && text_q.count > COUNT_BITS'(1) |-> text_q.digits[msd_idx] != '0)
		else $error("leading zero digit in gray value");

endmodule

### design/ascii_rgb_to_gray_text_converter.sv
// ----------------------------------------------------------------------------
// ascii_rgb_to_gray_text_converter
// Converts the ASCII pixel body of an RGB image into ASCII gray values.
// ----------------------------------------------------------------------------
// usage:
//   rgb_in takes one text byte per item; stream_end marks the end of input
//   and flushes a pending number. gray_out delivers one ASCII byte per item
//   (digits, space, newline), last_of_run marks the final byte of the run
//   caused by one input item.
//   cfg_we / cfg_index / cfg_data write image_width (index 0) and
//   image_height (index 1); write them only while the block is idle.
//   throughput: one input byte per cycle while the output keeps up; the
//   output register sends one byte per cycle while gray_out.ready is high,
//   up to 7 per pixel; the input stalls only once five pixels wait behind
//   the one being sent. path: a pixel whose blue value a delimiter finished
//   goes through the parser, sum, divide, quotient and digit stages, then
//   the output register, which sends its first byte.
//   reset: width and height return to 1, parser state and counters clear
//   and all stages empty. a stalled gray_out holds its byte and back-pressure
//   fills the five stages before rgb_in.ready drops.
// ----------------------------------------------------------------------------
module ascii_rgb_to_gray_text_converter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rgtg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rgtg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	rgtg_in_if.sink                              rgb_in,
	rgtg_out_if.source                           gray_out
);
	import rgtg_pkg::*;

	dims_t  dims_q;

	logic   pix_valid;
	logic   pix_ready;
	pixel_t pix;
	logic   gray_valid;
	logic   gray_ready;
	gray_t  gray;
	logic   text_valid;
	logic   text_ready;
	text_t  text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.width  <= dim_t'(1);
			dims_q.height <= dim_t'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  dims_q.width  <= dim_t'(cfg_data);
				REG_IMAGE_HEIGHT: dims_q.height <= dim_t'(cfg_data);
				default: ;
			endcase
		end
	end

	rgtg_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rgb_in    (rgb_in),
		.dims      (dims_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	rgtg_luma u_luma (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.gray_valid (gray_valid),
		.gray_ready (gray_ready),
		.gray       (gray)
	);

	rgtg_digits u_digits (
		.clk        (clk),
		.arst_n     (arst_n),
		.gray_valid (gray_valid),
		.gray_ready (gray_ready),
		.gray       (gray),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text)
	);

	rgtg_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.gray_out   (gray_out)
	);

endmodule
